@@ src/pfe_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared types and codes for the postfix expression evaluator.
// ----------------------------------------------------------------------------
package pfe_pkg;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_FULL    = 3'd1;
	localparam logic [2:0] ST_EMPTY   = 3'd2;
	localparam logic [2:0] ST_MISSING = 3'd3;
	localparam logic [2:0] ST_DIVZERO = 3'd4;
	localparam logic [2:0] ST_NOTHING = 3'd5;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_MUL   = 8'h2a;
	localparam logic [7:0] CH_DIV   = 8'h2f;
	localparam logic [7:0] CH_UPLUS = 8'h40;
	localparam logic [7:0] CH_UNEG  = 8'h24;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// stack cell control: normally every cell moves together; an in-place write of cell 0 holds the others
	typedef struct packed {
		logic push;   // shift down, new value enters cell 0
		logic pop1;   // shift up by one
		logic pop2;   // shift up by two
		logic wr_top; // overwrite cell 0 (after pop1/pop2 shift)
	} stk_ctl_t;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_MUL  = 3'b010,
		S_DIV  = 3'b100
	} pfe_state_t;

endpackage
`default_nettype wire

@@ src/pfe_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pfe_cell
// One stack cell: holds one value, takes from its neighbors on push/pop.
// ----------------------------------------------------------------------------
module pfe_cell #(
	parameter int W = 48
) (
	input  wire                 clk,
	input  wire pfe_pkg::stk_ctl_t ctl,
	input  wire         [W-1:0] from_up,   // cell above (toward top) value
	input  wire         [W-1:0] from_dn1,  // cell below
	input  wire         [W-1:0] from_dn2,  // two below
	input  wire         [W-1:0] top_val,   // only used by cell 0
	input  wire                 is_top,
	output logic        [W-1:0] val_q
);
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			val_q <= is_top ? top_val : from_up;
		end else if (ctl.pop2) begin
			val_q <= (ctl.wr_top && is_top) ? top_val : from_dn2;
		end else if (ctl.pop1) begin
			val_q <= (ctl.wr_top && is_top) ? top_val : from_dn1;
		end
	end
endmodule
`default_nettype wire

@@ src/pfe_muldiv.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pfe_muldiv
// Sequential saturating fixed-point multiply (shift-add) and divide (restoring).
// One bit per cycle.
// ----------------------------------------------------------------------------
module pfe_muldiv #(
	parameter int W = 48,
	parameter int F = 16
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          start_mul,
	input  wire          start_div,
	input  wire  [W-1:0] a,
	input  wire  [W-1:0] b,
	output logic         done,
	output logic [W-1:0] res
);
	localparam int PW = 2 * W + F;
	localparam int CW = $clog2(PW + 1);

	logic          busy_q, is_div_q, neg_q;
	logic [CW-1:0] cnt_q;
	logic [PW-1:0] acc_q;   // mul: product; div: quotient bits
	logic [PW-1:0] num_q;   // mul: shifting multiplicand; div: dividend bits
	logic [W-1:0]  y_q;     // mul: multiplier bits; div: divisor
	logic [W:0]    rem_q;
	logic          over_q;

	logic [W-1:0] ma, mb;
	assign ma = a[W-1] ? W'(-a) : a;
	assign mb = b[W-1] ? W'(-b) : b;

	logic [W:0] rsh;
	logic       ge;
	assign rsh = {rem_q[W-1:0], num_q[PW-1]};
	assign ge  = rsh >= {1'b0, y_q};

	// saturating final value from magnitude
	logic [PW-1:0] mag;
	logic          big;
	always_comb begin
		mag = is_div_q ? acc_q : (acc_q >> F);
		big = over_q || (mag > PW'({1'b0, {(W-1){1'b1}}}) + PW'(neg_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start_mul || start_div) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == CW'(0)) begin
				busy_q <= 1'b0;
				done   <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_mul || start_div) begin
			is_div_q <= start_div;
			neg_q    <= a[W-1] ^ b[W-1];
			over_q   <= 1'b0;
			acc_q    <= '0;
			rem_q    <= '0;
			if (start_div) begin
				num_q <= PW'(ma) << F;
				y_q   <= mb;
				cnt_q <= CW'(PW);
			end else begin
				num_q <= PW'(ma);
				y_q   <= mb;
				cnt_q <= CW'(W);
			end
		end else if (busy_q && cnt_q != CW'(0)) begin
			cnt_q <= cnt_q - CW'(1);
			if (is_div_q) begin
				num_q <= num_q << 1;
				if (acc_q[PW-1]) over_q <= 1'b1;
				acc_q <= {acc_q[PW-2:0], ge};
				rem_q <= ge ? (rsh - {1'b0, y_q}) : rsh;
			end else begin
				if (y_q[0]) acc_q <= acc_q + num_q;
				num_q <= num_q << 1;
				y_q   <= y_q >> 1;
			end
		end
	end

	always_comb begin
		if (big) res = neg_q ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		else     res = neg_q ? W'(-mag[W-1:0]) : mag[W-1:0];
	end
endmodule
`default_nettype wire

@@ src/postfix_expression_evaluator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Postfix character stream evaluator with a shifting stack of cells.
// ----------------------------------------------------------------------------
// Input channel: symbol with valid/ready, one ASCII character a beat.
// Output channel: result_value/status with valid/ready; one beat per NUL.
// Digits, '#', '+', '-', '@', '$', NUL and ignored characters are handled in S_IDLE;
// '*' and '/' hold the input while the bit-serial multiply/divide unit runs.
// NUL loads the output register; the result beat appears the next cycle.
// Input keeps flowing while a result waits; only the next NUL stalls until
// the receiver takes the pending beat, so a stalled receiver holds the block
// at that NUL.
// The stack is a row of STACK_DEPTH cells; push and pop shift the whole row,
// so the top is always cell 0. Reset clears count, number, error state and
// the output register.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator #(
	parameter int STACK_DEPTH = 16,
	parameter int VALUE_WIDTH = 48,
	parameter int FRAC_BITS   = 16
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           in_valid,
	output logic                          in_ready,
	input  wire  [7:0]                    symbol,
	output logic                          out_valid,
	input  wire                           out_ready,
	output logic signed [VALUE_WIDTH-1:0] result_value,
	output logic [2:0]                    status
);
	localparam int W  = VALUE_WIDTH;
	localparam int NW = $clog2(STACK_DEPTH + 1);

	pfe_pkg::pfe_state_t state_q;
	logic [NW-1:0] cnt_q;
	logic [W-1:0]  acc_q;
	logic          inprog_q;
	logic [2:0]    err_q;

	logic [W-1:0] cell_q [STACK_DEPTH];
	pfe_pkg::stk_ctl_t ctl;
	logic [W-1:0] top_val;

	logic          md_done;
	logic [W-1:0]  md_res;
	logic          start_mul, start_div;

	localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

	logic acc_fire;

	// digit accumulate
	logic [W-1:0]  dv, acc_next;
	logic [W+3:0]  acc10;
	logic          is_digit;
	always_comb begin
		is_digit = symbol >= pfe_pkg::CH_ZERO && symbol <= pfe_pkg::CH_NINE;
		dv       = W'(symbol - pfe_pkg::CH_ZERO) << FRAC_BITS;
		acc10    = (W+4)'(acc_q) * (W+4)'(10) + (W+4)'(dv);
		if ((FRAC_BITS + 4 >= W && (symbol - pfe_pkg::CH_ZERO) != 8'd0)
				|| acc10 > (W+4)'(VMAX))
			acc_next = VMAX;
		else
			acc_next = acc10[W-1:0];
	end

	// effective stack after implicit number end
	logic          is_bin, is_un, is_nul, is_hash;
	logic          npush, full_err;
	logic [NW-1:0] ecnt;
	logic [W-1:0]  r_v, l_v;
	always_comb begin
		is_nul  = symbol == pfe_pkg::CH_NUL;
		is_hash = symbol == pfe_pkg::CH_HASH;
		is_bin  = symbol == pfe_pkg::CH_PLUS || symbol == pfe_pkg::CH_MINUS
			|| symbol == pfe_pkg::CH_MUL || symbol == pfe_pkg::CH_DIV;
		is_un   = symbol == pfe_pkg::CH_UPLUS || symbol == pfe_pkg::CH_UNEG;
		npush   = inprog_q && (is_hash || is_bin || is_un || is_nul);
		full_err = npush && cnt_q >= NW'(STACK_DEPTH);
		ecnt    = (npush && !full_err) ? cnt_q + NW'(1) : cnt_q;
		// operands as seen after the number push
		r_v = (npush && !full_err) ? acc_q : cell_q[0];
		l_v = (npush && !full_err) ? cell_q[0] : cell_q[1];
	end

	// input is taken only in S_IDLE; a NUL also waits while the previous result beat is pending
	assign in_ready = (state_q == pfe_pkg::S_IDLE) && !(out_valid && is_nul);
	assign acc_fire = in_valid && in_ready;

	logic [W:0] sum_x, dif_x;
	logic [W-1:0] sum_s, dif_s, neg_s;
	always_comb begin
		sum_x = {l_v[W-1], l_v} + {r_v[W-1], r_v};
		dif_x = {l_v[W-1], l_v} - {r_v[W-1], r_v};
		sum_s = (sum_x[W] != sum_x[W-1]) ? (sum_x[W] ? VMIN : VMAX) : sum_x[W-1:0];
		dif_s = (dif_x[W] != dif_x[W-1]) ? (dif_x[W] ? VMIN : VMAX) : dif_x[W-1:0];
		neg_s = (r_v == VMIN) ? VMAX : W'(-r_v);
	end

	// control decode for an accepted symbol, and the pop when the multiply/divide unit is done
	logic [2:0]    new_err;
	logic [NW-1:0] cnt_n;
	always_comb begin
		ctl       = '0;
		top_val   = acc_q;
		new_err   = pfe_pkg::ST_OK;
		cnt_n     = cnt_q;
		start_mul = 1'b0;
		start_div = 1'b0;
		if (state_q == pfe_pkg::S_MUL || state_q == pfe_pkg::S_DIV) begin
			if (md_done) begin
				ctl.pop1 = 1'b1; ctl.wr_top = 1'b1; top_val = md_res;
				cnt_n = cnt_q - NW'(1);
			end
		end else if (acc_fire && err_q == pfe_pkg::ST_OK && !is_nul) begin
			if (full_err) begin
				new_err = pfe_pkg::ST_FULL;
			end else if (npush && !is_bin && !is_un) begin
				ctl.push = 1'b1;
				cnt_n = ecnt;
			end else if (is_bin || is_un) begin
				if (ecnt == NW'(0)) begin
					new_err = pfe_pkg::ST_EMPTY;
					if (npush) begin ctl.push = 1'b1; cnt_n = ecnt; end
				end else if (is_un) begin
					cnt_n = ecnt;
					if (npush) ctl.push = 1'b1;
					else begin ctl.pop1 = 1'b1; ctl.pop2 = 1'b0; end
					if (!npush) begin
						// pop then write top in place: shift by zero
						ctl.pop1 = 1'b0;
						ctl.push = 1'b0;
					end
					if (symbol == pfe_pkg::CH_UNEG) begin
						if (npush) top_val = neg_s;
						else begin ctl.pop2 = 1'b0; end
					end
				end else if (ecnt == NW'(1)) begin
					new_err = pfe_pkg::ST_MISSING;
					if (npush) begin ctl.push = 1'b1; cnt_n = ecnt; end
				end else if (symbol == pfe_pkg::CH_DIV && r_v == '0) begin
					new_err = pfe_pkg::ST_DIVZERO;
					if (npush) begin ctl.push = 1'b1; cnt_n = ecnt; end
				end else if (symbol == pfe_pkg::CH_MUL || symbol == pfe_pkg::CH_DIV) begin
					// leave operands on the stack; pop when the unit is done
					if (npush) begin ctl.push = 1'b1; end
					cnt_n     = ecnt;
					start_mul = symbol == pfe_pkg::CH_MUL;
					start_div = symbol == pfe_pkg::CH_DIV;
				end else begin
					top_val = (symbol == pfe_pkg::CH_PLUS) ? sum_s : dif_s;
					ctl.wr_top = 1'b1;
					if (npush) ctl.pop1 = 1'b0;
					else ctl.pop1 = 1'b1;
					cnt_n = ecnt - NW'(1);
				end
			end
		end
	end

	// unary negate of an existing top done in place on cell 0 via a separate write
	logic un_inplace;
	assign un_inplace = acc_fire && err_q == pfe_pkg::ST_OK && is_un && !full_err
		&& ecnt != NW'(0) && !npush && symbol == pfe_pkg::CH_UNEG;

	// binary add/sub when the number was just ended: result replaces cell 0
	logic bin_inpl;
	assign bin_inpl = ctl.wr_top && !ctl.pop1 && !ctl.pop2 && !ctl.push;

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		pfe_pkg::stk_ctl_t cctl;
		logic [W-1:0] tv;
		always_comb begin
			cctl = ctl;
			tv   = top_val;
			if (un_inplace || bin_inpl) begin
				cctl = '0;
				cctl.pop1 = (i == 0);
				cctl.wr_top = 1'b1;
				tv = un_inplace ? neg_s : top_val;
			end
		end
		pfe_cell #(.W(W)) u_cell (
			.clk      (clk),
			.ctl      (cctl),
			.from_up  (i == 0 ? '0 : cell_q[(i == 0) ? 0 : i-1]),
			.from_dn1 (i + 1 < STACK_DEPTH ? cell_q[(i + 1 < STACK_DEPTH) ? i+1 : i] : '0),
			.from_dn2 (i + 2 < STACK_DEPTH ? cell_q[(i + 2 < STACK_DEPTH) ? i+2 : i] : '0),
			.top_val  (tv),
			.is_top   (i == 0),
			.val_q    (cell_q[i])
		);
	end

	pfe_muldiv #(.W(W), .F(FRAC_BITS)) u_md (
		.clk       (clk),
		.arst_n    (arst_n),
		.start_mul (start_mul),
		.start_div (start_div),
		.a         (l_v),
		.b         (r_v),
		.done      (md_done),
		.res       (md_res)
	);

	// NUL result
	logic [W-1:0] fin_v;
	logic [2:0]   fin_s;
	always_comb begin
		fin_v = '0;
		if (err_q != pfe_pkg::ST_OK) fin_s = err_q;
		else if (full_err) fin_s = pfe_pkg::ST_FULL;
		else if (ecnt == NW'(0)) fin_s = pfe_pkg::ST_NOTHING;
		else begin
			fin_s = pfe_pkg::ST_OK;
			fin_v = r_v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= pfe_pkg::S_IDLE;
			cnt_q        <= '0;
			acc_q        <= '0;
			inprog_q     <= 1'b0;
			err_q        <= pfe_pkg::ST_OK;
			out_valid    <= 1'b0;
			result_value <= '0;
			status       <= pfe_pkg::ST_OK;
		end else begin
			unique case (state_q)
				pfe_pkg::S_IDLE: begin
					if (acc_fire) begin
						if (is_nul) begin
							result_value <= fin_v;
							status       <= fin_s;
							cnt_q        <= '0;
							acc_q        <= '0;
							inprog_q     <= 1'b0;
							err_q        <= pfe_pkg::ST_OK;
						end else if (err_q == pfe_pkg::ST_OK) begin
							cnt_q <= cnt_n;
							if (new_err != pfe_pkg::ST_OK) err_q <= new_err;
							if (is_digit) begin
								acc_q    <= acc_next;
								inprog_q <= 1'b1;
							end else if (npush) begin
								acc_q    <= '0;
								inprog_q <= 1'b0;
							end
							if (start_mul) state_q <= pfe_pkg::S_MUL;
							if (start_div) state_q <= pfe_pkg::S_DIV;
						end
					end
				end
				pfe_pkg::S_MUL, pfe_pkg::S_DIV: begin
					if (md_done) begin
						cnt_q   <= cnt_n;
						state_q <= pfe_pkg::S_IDLE;
					end
				end
				default: state_q <= pfe_pkg::S_IDLE;
			endcase
			// a NUL is only taken while the output register is empty
			if (acc_fire && is_nul) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= NW'(STACK_DEPTH)) else $error("stack count out of range");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
		(out_valid && $stable(result_value) && $stable(status)))
		else $error("result beat changed while stalled");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= pfe_pkg::ST_NOTHING) else $error("bad status");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != pfe_pkg::ST_OK) |-> result_value == '0)
		else $error("nonzero value on error");
`endif
endmodule
`default_nettype wire

@@ bench/postfix_expression_evaluator_tb.sv @@
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_tb
// Self-checking bench: postfix character streams go in, each NUL beat is
// predicted by an in-bench RPN evaluator and compared against the output.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_tb;

	localparam int DEPTH = 16;
	localparam int VW    = 48;
	localparam int FB    = 16;

	typedef logic signed [VW-1:0] val_t;
	typedef logic signed [127:0]  wide_t;

	typedef struct {
		val_t       value;
		logic [2:0] code;
	} rpn_result_t;

	class rpn_scoreboard;
		val_t        stk[DEPTH];
		int          cnt;
		logic [63:0] acc;
		bit          in_num;
		logic [2:0]  err;
		rpn_result_t pending[$];
		int          fails;

		function new();
			fails = 0;
			clear();
		endfunction

		function void clear();
			cnt = 0;
			acc = '0;
			in_num = 0;
			err = pfe_pkg::ST_OK;
		endfunction

		function val_t clamp(wide_t x);
			wide_t vmax, vmin;
			vmax = (wide_t'(1) <<< (VW-1)) - 1;
			vmin = -vmax - 1;
			if (x > vmax) return vmax[VW-1:0];
			if (x < vmin) return vmin[VW-1:0];
			return x[VW-1:0];
		endfunction

		function void raise_err(logic [2:0] c);
			if (err == pfe_pkg::ST_OK) err = c;
		endfunction

		function void push(val_t v);
			if (cnt >= DEPTH) begin
				raise_err(pfe_pkg::ST_FULL);
				return;
			end
			stk[cnt] = v;
			cnt++;
		endfunction

		function void end_number();
			if (in_num) begin
				push(val_t'(acc[VW-1:0]));
				in_num = 0;
				acc = '0;
			end
		endfunction

		// product and quotient work on magnitudes, so truncation is toward zero
		function val_t apply(logic [7:0] op, val_t l, val_t r);
			wide_t a, b, m;
			bit neg;
			a = l;
			b = r;
			neg = (l < 0) != (r < 0);
			if (a < 0) a = -a;
			if (b < 0) b = -b;
			case (op)
				pfe_pkg::CH_PLUS:  return clamp(wide_t'(l) + wide_t'(r));
				pfe_pkg::CH_MINUS: return clamp(wide_t'(l) - wide_t'(r));
				pfe_pkg::CH_MUL: begin
					m = (a * b) >>> FB;
					return clamp(neg ? -m : m);
				end
				default: begin
					m = (a <<< FB) / b;
					return clamp(neg ? -m : m);
				end
			endcase
		endfunction

		function void note_symbol(logic [7:0] c);
			rpn_result_t res;
			val_t l, r;
			logic [63:0] umax, dv;
			umax = (64'd1 << (VW-1)) - 1;
			if (c == pfe_pkg::CH_NUL) begin
				res.value = '0;
				if (err == pfe_pkg::ST_OK) end_number();
				if (err != pfe_pkg::ST_OK) res.code = err;
				else if (cnt > 0) begin
					res.code = pfe_pkg::ST_OK;
					res.value = stk[cnt-1];
				end else res.code = pfe_pkg::ST_NOTHING;
				pending.push_back(res);
				clear();
				return;
			end
			if (err != pfe_pkg::ST_OK) return;
			if (c >= pfe_pkg::CH_ZERO && c <= pfe_pkg::CH_NINE) begin
				dv = 64'(c - pfe_pkg::CH_ZERO) << FB;
				if (acc > (umax - dv) / 10) acc = umax;
				else acc = acc * 10 + dv;
				in_num = 1;
			end else if (c == pfe_pkg::CH_HASH) begin
				end_number();
			end else if (c == pfe_pkg::CH_PLUS || c == pfe_pkg::CH_MINUS
					|| c == pfe_pkg::CH_MUL || c == pfe_pkg::CH_DIV) begin
				end_number();
				if (err != pfe_pkg::ST_OK) return;
				if (cnt == 0) begin
					raise_err(pfe_pkg::ST_EMPTY);
					return;
				end
				cnt--;
				r = stk[cnt];
				if (cnt == 0) begin
					raise_err(pfe_pkg::ST_MISSING);
					return;
				end
				cnt--;
				l = stk[cnt];
				if (c == pfe_pkg::CH_DIV && r == 0) raise_err(pfe_pkg::ST_DIVZERO);
				else push(apply(c, l, r));
			end else if (c == pfe_pkg::CH_UPLUS || c == pfe_pkg::CH_UNEG) begin
				end_number();
				if (err != pfe_pkg::ST_OK) return;
				if (cnt == 0) begin
					raise_err(pfe_pkg::ST_EMPTY);
					return;
				end
				cnt--;
				r = stk[cnt];
				push(c == pfe_pkg::CH_UNEG ? clamp(-wide_t'(r)) : r);
			end
		endfunction

		function void check_result(val_t v, logic [2:0] s);
			rpn_result_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result beat value=%0d status=%0d", $time, v, s);
				fails++;
				return;
			end
			e = pending.pop_front();
			if (v !== e.value) begin
				$display("%0t: result_value expected %0d actual %0d", $time, e.value, v);
				fails++;
			end
			if (s !== e.code) begin
				$display("%0t: status expected %0d actual %0d", $time, e.code, s);
				fails++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] symbol;
	logic       out_valid;
	logic       out_ready;
	val_t       result_value;
	logic [2:0] status;

	rpn_scoreboard sb;
	int snd_idle, rcv_idle, hold_cycles, sent;

	postfix_expression_evaluator u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .symbol(symbol),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_value(result_value), .status(status)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else out_ready <= ($urandom_range(0, 99) >= rcv_idle);
	end

	always @(posedge clk)
		if (arst_n && out_valid && out_ready) sb.check_result(result_value, status);

	task send(logic [7:0] c);
		if ($urandom_range(0, 99) < snd_idle) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		in_valid = 1'b1;
		symbol = c;
		do @(posedge clk); while (!in_ready);
		sb.note_symbol(c);
		sent++;
		@(negedge clk);
	endtask

	task send_str(string s);
		for (int i = 0; i < s.len(); i++) send(s[i]);
		send(pfe_pkg::CH_NUL);
	endtask

	task send_number(int ndig);
		for (int i = 0; i < ndig; i++)
			send(pfe_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
	endtask

	// mostly well-formed expressions; the rest noise, overfull or broken
	task send_expr();
		int kind, depth, n, pick;
		logic [7:0] ops[6];
		ops = '{pfe_pkg::CH_PLUS, pfe_pkg::CH_MINUS, pfe_pkg::CH_MUL, pfe_pkg::CH_DIV,
			pfe_pkg::CH_UPLUS, pfe_pkg::CH_UNEG};
		kind = $urandom_range(0, 99);
		depth = 0;
		if (kind < 75) begin
			n = $urandom_range(1, 12);
			for (int i = 0; i < n; i++) begin
				if (depth < 2 && $urandom_range(0, 3) != 0 || $urandom_range(0, 2) == 0) begin
					send_number($urandom_range(0, 19) == 0 ? $urandom_range(9, 16)
						: $urandom_range(1, 3));
					if ($urandom_range(0, 4) != 0) send(pfe_pkg::CH_HASH);
					depth++;
				end else begin
					pick = $urandom_range(0, 9);
					pick = pick < 6 ? pick : (pick < 8 ? 0 : 5);
					send(ops[pick]);
					if (pick < 4) depth--;
				end
				if ($urandom_range(0, 15) == 0) send(8'($urandom_range(97, 255)));
			end
		end else if (kind < 85) begin
			n = $urandom_range(15, 19);
			for (int i = 0; i < n; i++) begin
				send_number(1);
				send(pfe_pkg::CH_HASH);
			end
			send(ops[$urandom_range(0, 5)]);
		end else begin
			n = $urandom_range(1, 20);
			for (int i = 0; i < n; i++)
				send($urandom_range(0, 1) ? 8'($urandom_range(1, 255))
					: 8'($urandom_range(pfe_pkg::CH_UNEG, pfe_pkg::CH_NINE)));
		end
		send(pfe_pkg::CH_NUL);
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		symbol = pfe_pkg::CH_NUL;
		out_ready = 1'b0;
		hold_cycles = 0;
		sent = 0;
		snd_idle = 23;
		rcv_idle = 88;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_str("9#4+2*1-");
		send_str("7#2/$");
		send_str("5#0/");
		send_str("$");
		send_str("3+");
		send(pfe_pkg::CH_NUL);
		send_str("#\xff3@");

		for (int ph = 0; ph < 3; ph++) begin
			if (ph == 1) begin
				snd_idle = 88;
				rcv_idle = 23;
			end else if (ph == 2) begin
				snd_idle = 0;
				rcv_idle = 0;
			end
			hold_cycles = 400;
			while (sent < 30 + 620 * (ph + 1)) send_expr();
			in_valid = 1'b0;
			while (sb.pending.size() != 0) @(posedge clk);
			@(negedge clk);
		end

		repeat (300) @(posedge clk);
		if (sb.fails == 0 && sb.pending.size() == 0)
			$display("postfix_expression_evaluator verification clean");
		else
			$display("postfix_expression_evaluator verification failed");
		$finish;
	end

	initial begin
		#50000000;
		$display("postfix_expression_evaluator verification failed");
		$finish;
	end

endmodule
